[rtl/tfds_pkg.sv]
// Shared constants, types and widths for the transmit sample FIFO and DAC scaler.
`default_nettype none
package tfds_pkg;

    localparam int FIFO_DEPTH = 16384;
    localparam int MAX_BLOCK  = 8192;

    localparam int AW         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SLOT_W     = $clog2(MAX_BLOCK + 1);

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 12;
    localparam int DAC_W      = 16;
    localparam int PCT_W      = 7;
    localparam int FRAC_W     = 20;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int SQ_W       = 2 * DAC_W;
    localparam int SUM_W      = 2 * (DAC_W - 1) + SLOT_W;

    localparam int SQRT_IN_W  = 2 * DAC_W;
    localparam int SQRT_STEPS = SQRT_IN_W / 2;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int REM_W      = (SLOT_W + 1 > DAC_W + 4) ? SLOT_W + 1 : DAC_W + 4;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1400);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_PULL = 1'b1
    } t_cmd;

    typedef enum logic {
        M_DIV,
        M_SQRT
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_req;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_req;

endpackage
`default_nettype wire

[rtl/tx_sample_fifo_dac_scaler_top.sv]
// Top level: stream sequencer, gain and saturation, block statistics.
//
//  channel  | direction | handshake                    | content
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata sample, tuser cmd, tlast block_last
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata dac/rms/peak/pct, tuser starved,
//           |           |                              | tlast block_done
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | dac_gain
//
// Ready stays high across consecutive pushes. A pull goes through memory read,
// gain multiply, saturate, square and accumulate to a waiting result; a pull that
// closes a block then also passes through the shared divide/root unit
// (44-step divide, 16-step root, 44-step divide).
// Input ready is low from a pull until its result is taken downstream.
// Reset is synchronous; the sample store holds no reset and needs no clearing pass.
`default_nettype none
module tx_sample_fifo_dac_scaler_top
    import tfds_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [23:0]       s_axis_tdata,  // [23:0] sample
    input  wire logic              s_axis_tuser,  // [0] cmd
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [55:0]       m_axis_tdata,  // [15:0] dac_value, [31:16] block_rms,
                                                  // [47:32] block_peak, [54:48] starved_percent
    output logic                   m_axis_tuser,  // [0] slot_starved
    output logic                   m_axis_tlast,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [GAIN_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SAT, S_SQR, S_ACC,
        S_D1GO, S_D1, S_SQGO, S_SQ, S_D2GO, S_D2, S_OUT
    } t_state;

    t_state                    r_state, n_state;
    logic [GAIN_W-1:0]         r_gain;
    logic                      r_stv, n_stv;
    logic                      r_last, n_last;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [DAC_W-1:0]   r_dac, n_dac;
    logic [DAC_W-1:0]          r_mag, n_mag;
    logic [SQ_W-1:0]           r_sq, n_sq;
    logic [SLOT_W-1:0]         r_slots, n_slots;
    logic [SLOT_W-1:0]         r_nstv, n_nstv;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [DAC_W-1:0]          r_peak, n_peak;
    logic                      r_done, n_done;
    logic [DAC_W-1:0]          r_rms, n_rms;
    logic [DAC_W-1:0]          r_opeak, n_opeak;
    logic [PCT_W-1:0]          r_pct, n_pct;

    t_fifo_req                 w_fifo_req;
    logic [SAMPLE_W-1:0]       w_rdata;
    logic                      w_empty;
    t_iter_req                 w_iter_req;
    logic [SUM_W-1:0]          w_operand;
    logic                      w_iter_done;
    logic [SUM_W-1:0]          w_iter_res;
    logic                      w_accept;

    logic signed [DAC_W+1:0]   w_q;
    logic [SLOT_W-1:0]         w_slots_inc;
    logic                      w_blk_end;
    logic [SUM_W-1:0]          w_pct_num;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    assign w_fifo_req.push = w_accept && (s_axis_tuser == CMD_PUSH);
    assign w_fifo_req.pop  = w_accept && (s_axis_tuser == CMD_PULL);

    tfds_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_fifo_req),
        .i_wdata (s_axis_tdata[SAMPLE_W-1:0]),
        .o_rdata (w_rdata),
        .o_empty (w_empty)
    );

    tfds_iter u_iter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_iter_req),
        .i_operand (w_operand),
        .i_divisor (r_slots),
        .o_done    (w_iter_done),
        .o_result  (w_iter_res)
    );

    assign w_q = $signed({r_prod[PROD_W-1], r_prod[PROD_W-1:FRAC_W]})
               + $signed({(DAC_W+1)'(0), (r_prod[PROD_W-1] && (r_prod[FRAC_W-1:0] != '0))});
    assign w_slots_inc = r_slots + SLOT_W'(1);
    assign w_blk_end   = r_last || (w_slots_inc >= SLOT_W'(MAX_BLOCK));
    assign w_pct_num   = SUM_W'({r_nstv, 6'b0}) + SUM_W'({r_nstv, 5'b0})
                       + SUM_W'({r_nstv, 2'b0});

    always_comb begin
        w_iter_req.start = 1'b0;
        w_iter_req.mode  = M_DIV;
        w_operand        = r_sum;
        case (r_state)
            S_D1GO: begin
                w_iter_req.start = 1'b1;
            end
            S_SQGO: begin
                w_iter_req.start = 1'b1;
                w_iter_req.mode  = M_SQRT;
                w_operand        = w_iter_res;
            end
            S_D2GO: begin
                w_iter_req.start = 1'b1;
                w_operand        = w_pct_num;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_stv   = r_stv;
        n_last  = r_last;
        n_prod  = r_prod;
        n_dac   = r_dac;
        n_mag   = r_mag;
        n_sq    = r_sq;
        n_slots = r_slots;
        n_nstv  = r_nstv;
        n_sum   = r_sum;
        n_peak  = r_peak;
        n_done  = r_done;
        n_rms   = r_rms;
        n_opeak = r_opeak;
        n_pct   = r_pct;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (s_axis_tuser == CMD_PULL)) begin
                    n_stv   = w_empty;
                    n_last  = s_axis_tlast;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = PROD_W'($signed(w_rdata)) * PROD_W'($signed({1'b0, r_gain}));
                if (r_stv) begin
                    n_prod = '0;
                end
                n_state = S_SAT;
            end
            S_SAT: begin
                if (w_q > $signed((DAC_W+2)'(32767))) begin
                    n_dac = DAC_W'(32767);
                end else if (w_q < -$signed((DAC_W+2)'(32768))) begin
                    n_dac = $signed({1'b1, (DAC_W-1)'(0)});
                end else begin
                    n_dac = w_q[DAC_W-1:0];
                end
                n_mag   = n_dac[DAC_W-1] ? DAC_W'(~n_dac + DAC_W'(1)) : n_dac;
                n_state = S_SQR;
            end
            S_SQR: begin
                n_sq    = r_mag * r_mag;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_slots = w_slots_inc;
                n_nstv  = r_nstv + SLOT_W'(r_stv);
                n_sum   = r_sum + SUM_W'(r_sq);
                n_peak  = (r_mag > r_peak) ? r_mag : r_peak;
                n_done  = w_blk_end;
                n_rms   = '0;
                n_opeak = '0;
                n_pct   = '0;
                n_state = w_blk_end ? S_D1GO : S_OUT;
            end
            S_D1GO: n_state = S_D1;
            S_D1: begin
                if (w_iter_done) begin
                    n_state = S_SQGO;
                end
            end
            S_SQGO: n_state = S_SQ;
            S_SQ: begin
                if (w_iter_done) begin
                    n_rms   = w_iter_res[DAC_W-1:0];
                    n_state = S_D2GO;
                end
            end
            S_D2GO: n_state = S_D2;
            S_D2: begin
                if (w_iter_done) begin
                    n_pct   = w_iter_res[PCT_W-1:0];
                    n_opeak = r_peak;
                    n_slots = '0;
                    n_nstv  = '0;
                    n_sum   = '0;
                    n_peak  = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gain  <= GAIN_RESET;
            r_slots <= '0;
            r_nstv  <= '0;
            r_sum   <= '0;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            r_slots <= n_slots;
            r_nstv  <= n_nstv;
            r_sum   <= n_sum;
            r_peak  <= n_peak;
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
        end
        r_stv   <= n_stv;
        r_last  <= n_last;
        r_prod  <= n_prod;
        r_dac   <= n_dac;
        r_mag   <= n_mag;
        r_sq    <= n_sq;
        r_done  <= n_done;
        r_rms   <= n_rms;
        r_opeak <= n_opeak;
        r_pct   <= n_pct;
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_pct, r_opeak, r_rms, r_dac};
    assign m_axis_tuser  = r_stv;
    assign m_axis_tlast  = r_done;

endmodule
`default_nettype wire

[rtl/tfds_fifo.sv]
// Circular sample store with overwrite of the oldest entry when full.
`default_nettype none
module tfds_fifo
    import tfds_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_fifo_req           i_req,
    input  wire logic [SAMPLE_W-1:0] i_wdata,
    output logic      [SAMPLE_W-1:0] o_rdata,
    output logic                     o_empty
);

    logic [SAMPLE_W-1:0] r_mem [FIFO_DEPTH];
    logic [AW-1:0]       r_rd;
    logic [AW-1:0]       r_wr;
    logic [CNT_W-1:0]    r_fill;
    logic [SAMPLE_W-1:0] r_rdata;
    logic                w_full;
    logic                w_pop;

    assign w_full  = (r_fill == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_fill == '0);
    assign w_pop   = i_req.pop && !o_empty;
    assign o_rdata = r_rdata;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_wr] <= i_wdata;
        end
        if (w_pop) begin
            r_rdata <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_wr   <= '0;
            r_fill <= '0;
        end else if (i_req.push) begin
            r_wr <= wrap_inc(r_wr);
            if (w_full) begin
                r_rd <= wrap_inc(r_rd);
            end else begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end else if (w_pop) begin
            r_rd   <= wrap_inc(r_rd);
            r_fill <= r_fill - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

[rtl/tfds_iter.sv]
// Shared shift-subtract unit: restoring divide or digit-by-digit square root, one step a cycle.
`default_nettype none
module tfds_iter
    import tfds_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_iter_req         i_req,
    input  wire logic [SUM_W-1:0]  i_operand,
    input  wire logic [SLOT_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [SUM_W-1:0]  o_result
);

    t_iter_mode          r_mode;
    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [SUM_W-1:0]    r_opd;
    logic [SUM_W-1:0]    r_q;
    logic [REM_W-1:0]    r_rem;
    logic [SLOT_W-1:0]   r_div;

    logic [REM_W-1:0]    w_shift;
    logic [REM_W-1:0]    w_trial;
    logic [REM_W:0]      w_diff;
    logic                w_ge;

    always_comb begin
        if (r_mode == M_SQRT) begin
            w_shift = {r_rem[REM_W-3:0], r_opd[SUM_W-1 -: 2]};
            w_trial = REM_W'({r_q[DAC_W-1:0], 2'b01});
        end else begin
            w_shift = {r_rem[REM_W-2:0], r_opd[SUM_W-1]};
            w_trial = REM_W'(r_div);
        end
        w_diff = {1'b0, w_shift} - {1'b0, w_trial};
        w_ge   = !w_diff[REM_W];
    end

    assign o_done   = r_done;
    assign o_result = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mode <= M_DIV;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_rem  <= '0;
                r_q    <= '0;
                r_div  <= i_divisor;
                if (i_req.mode == M_SQRT) begin
                    r_opd <= {i_operand[SQRT_IN_W-1:0], (SUM_W - SQRT_IN_W)'(0)};
                    r_cnt <= STEP_W'(SQRT_STEPS - 1);
                end else begin
                    r_opd <= i_operand;
                    r_cnt <= STEP_W'(DIV_STEPS - 1);
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[REM_W-1:0] : w_shift;
                r_q   <= {r_q[SUM_W-2:0], w_ge};
                r_opd <= (r_mode == M_SQRT) ? {r_opd[SUM_W-3:0], 2'b00}
                                            : {r_opd[SUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/tfds_checker.sv]
// Port-level checks on the scaler top, bound to every instance.
`default_nettype none
module tfds_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transaction dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input taken while a result transaction waits");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[54:48] <= 7'd100)
        else $error("starved percentage above 100");

    a_stats_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[54:16] == 39'd0)
        else $error("statistics nonzero outside block end");

    a_push_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !m_axis_tvalid)
        else $error("push produced a result transaction");

endmodule

bind tx_sample_fifo_dac_scaler_top tfds_checker u_tfds_checker (.*);
`default_nettype wire

[verif/tb_tx_sample_fifo_dac_scaler_top.sv]
// Self-checking testbench for the transmit sample FIFO and DAC scaler top level.
`default_nettype none
module tb_tx_sample_fifo_dac_scaler_top
    import tfds_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 150;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 255;
    localparam int MAX_REPORTS    = 50;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_GAIN = 1'b1
    } t_row_kind;

    typedef struct packed {
        logic signed [15:0] dac;
        logic               starved;
        logic               done;
        logic [15:0]        rms;
        logic [15:0]        peak;
        logic [6:0]         pct;
    } t_slot_result;

    typedef struct packed {
        t_row_kind         kind;
        logic [GAIN_W-1:0] gain;
        t_cmd              cmd;
        logic [23:0]       data;
        logic              last;
        logic              typed;
        t_slot_result      want;
    } t_stim_row;

    localparam t_slot_result NO_SLOT = '0;

    localparam t_stim_row DIRECTED [26] = '{
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b1, 1'b1,
          '{16'sd0, 1'b1, 1'b1, 16'd0, 16'd0, 7'd100}},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'hABCDEF, 1'b0, 1'b1,
          '{16'sd0, 1'b1, 1'b0, 16'd0, 16'd0, 7'd0}},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h7FFFFF, 1'b1, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h800000, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h000000, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h000001, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'hFFFFFF, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h5A5A5A, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b0, 1'b1,
          '{-16'sd11200, 1'b0, 1'b0, 16'd0, 16'd0, 7'd0}},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b0, 1'b1,
          '{16'sd0, 1'b0, 1'b0, 16'd0, 16'd0, 7'd0}},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b1, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b1, 1'b1,
          '{16'sd0, 1'b1, 1'b1, 16'd0, 16'd0, 7'd100}},
        '{ROW_GAIN, 12'd4095, CMD_PUSH, 24'h000000, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h800000, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h7FFFFF, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b0, 1'b1,
          '{-16'sd32760, 1'b0, 1'b0, 16'd0, 16'd0, 7'd0}},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b1, 1'b0, NO_SLOT},
        '{ROW_GAIN, 12'd0, CMD_PUSH, 24'h000000, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h7FFFFF, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b1, 1'b1,
          '{16'sd0, 1'b0, 1'b1, 16'd0, 16'd0, 7'd0}},
        '{ROW_GAIN, 12'd1, CMD_PUSH, 24'h000000, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h800000, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PUSH, 24'h7FFFFF, 1'b0, 1'b0, NO_SLOT},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b0, 1'b1,
          '{-16'sd8, 1'b0, 1'b0, 16'd0, 16'd0, 7'd0}},
        '{ROW_ITEM, 12'd0, CMD_PULL, 24'h000000, 1'b1, 1'b0, NO_SLOT}
    };

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata  = '0;  // [23:0] sample
    logic              s_axis_tuser  = 1'b0;  // [0] cmd
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [55:0]       m_axis_tdata;  // [15:0] dac_value, [31:16] block_rms,
                                      // [47:32] block_peak, [54:48] starved_percent
    logic              m_axis_tuser;  // [0] slot_starved
    logic              m_axis_tlast;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [GAIN_W-1:0] i_cfg_data    = '0;

    tx_sample_fifo_dac_scaler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // FIFO and block statistics as the block should hold them
    logic signed [23:0] model_fifo [$];
    logic [GAIN_W-1:0]  model_gain = GAIN_RESET;
    int unsigned        blk_slots;
    int unsigned        blk_starved;
    longint unsigned    blk_square_sum;
    int unsigned        blk_peak;

    t_slot_result pending_slots [$];
    t_slot_result got_slot;
    t_slot_result want_slot;

    int  mismatches;
    int  n_results;
    int  n_push, n_pull, n_dropped, n_starved, n_blocks, n_limit_blocks, n_gains;
    bit  tx_gapless;
    bit  rx_gapless;
    int  rx_wait;
    int  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] scale_to_dac(logic signed [23:0] s);
        longint prod;
        longint q;
        prod = longint'(s) * longint'({1'b0, model_gain});
        q = prod / 1048576;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= x) root = cand;
        end
        return root;
    endfunction

    task automatic step_fifo_model(input t_cmd cmd, input logic [23:0] data, input logic last,
                                   output bit has_res, output t_slot_result res);
        logic signed [15:0] v;
        int unsigned        mag;
        bit                 done;
        res = '0;
        has_res = 1'b0;
        if (cmd == CMD_PUSH) begin
            if (model_fifo.size() >= FIFO_DEPTH) begin
                void'(model_fifo.pop_front());
                n_dropped++;
            end
            model_fifo.insert(model_fifo.size(), $signed(data));
            n_push++;
        end else begin
            has_res = 1'b1;
            n_pull++;
            v = '0;
            if (model_fifo.size() > 0) begin
                v = scale_to_dac(model_fifo.pop_front());
            end else begin
                res.starved = 1'b1;
                n_starved++;
            end
            mag = (v < 0) ? int'(-int'(v)) : int'(v);
            blk_slots++;
            blk_starved += res.starved;
            blk_square_sum += longint'(mag) * longint'(mag);
            if (mag > blk_peak) blk_peak = mag;
            done = last || (blk_slots >= MAX_BLOCK);
            res.dac = v;
            res.done = done;
            if (done) begin
                res.rms  = 16'(floor_sqrt(blk_square_sum / longint'(blk_slots)));
                res.pct  = 7'((longint'(blk_starved) * 100) / longint'(blk_slots));
                res.peak = 16'(blk_peak);
                n_blocks++;
                if (!last) n_limit_blocks++;
                blk_slots      = 0;
                blk_starved    = 0;
                blk_square_sum = 0;
                blk_peak       = 0;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      n_results, name, got, want));
    endtask

    function automatic logic [23:0] pick_sample();
        int near_zero;
        near_zero = int'($urandom_range(0, 32)) - 16;
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(near_zero);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [23:0] data, input logic last,
                             input bit typed, input t_slot_result want);
        int           gap;
        bit           has_res;
        t_slot_result res;
        gap = tx_gapless ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        step_fifo_model(cmd, data, last, has_res, res);
        if (has_res) pending_slots.insert(pending_slots.size(), typed ? want : res);
    endtask

    // hold the sender until every pending slot has been taken
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_slots.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic program_gain(input logic [GAIN_W-1:0] gain);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_gain = gain;
        n_gains++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                got_slot = '{dac: m_axis_tdata[15:0], starved: m_axis_tuser,
                             done: m_axis_tlast, rms: m_axis_tdata[31:16],
                             peak: m_axis_tdata[47:32], pct: m_axis_tdata[54:48]};
                if (pending_slots.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              n_results));
                end else begin
                    want_slot = pending_slots.pop_front();
                    check_field("dac_value", got_slot.dac, want_slot.dac);
                    check_field("slot_starved", got_slot.starved, want_slot.starved);
                    check_field("block_done", got_slot.done, want_slot.done);
                    check_field("block_rms", got_slot.rms, want_slot.rms);
                    check_field("block_peak", got_slot.peak, want_slot.peak);
                    check_field("starved_percent", got_slot.pct, want_slot.pct);
                end
                if ($urandom_range(0, 31) == 0) rx_gapless = !rx_gapless;
                rx_wait = rx_gapless ? 0 : $urandom_range(0, 14);
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d slots pending",
                         quiet_cycles, pending_slots.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int   push_pct;
        int   last_odds;
        t_cmd cmd;
        logic [GAIN_W-1:0] gain;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_GAIN) begin
                program_gain(DIRECTED[r].gain);
            end else begin
                send_item(DIRECTED[r].cmd, DIRECTED[r].data, DIRECTED[r].last,
                          DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            gain = (ph == 0) ? 12'd4095 : (ph == 1) ? 12'd0 : (ph == 3) ? 12'd1 :
                   12'($urandom_range(2, 4094));
            program_gain(gain);
            push_pct  = $urandom_range(30, 70);
            last_odds = $urandom_range(2, 16);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0) tx_gapless = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 49) == 0) hold_until_drained();
                cmd = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_PULL;
                send_item(cmd, (cmd == CMD_PUSH) ? pick_sample() : 24'($urandom),
                          (cmd == CMD_PUSH) ? 1'($urandom_range(0, 1)) :
                                              ($urandom_range(1, last_odds) == 1),
                          1'b0, NO_SLOT);
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_slots.size() != 0)
            report_mismatch($sformatf("%0d slots never arrived", pending_slots.size()));
        $display("covered %0d pushes (%0d dropped the oldest), %0d pulls (%0d starved)",
                 n_push, n_dropped, n_pull, n_starved);
        $display("closed %0d blocks (%0d at the slot limit) over %0d gain settings",
                 n_blocks, n_limit_blocks, n_gains);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
rtl/tfds_pkg.sv
rtl/tfds_fifo.sv
rtl/tfds_iter.sv
rtl/tx_sample_fifo_dac_scaler_top.sv
rtl/tfds_checker.sv
verif/tb_tx_sample_fifo_dac_scaler_top.sv
